// ===== hw/rtl/u8san_pkg.sv =====
`timescale 1ns / 1ps

package u8san_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] held_cnt_t;
  typedef logic [2:0] seq_len_t;
  typedef logic [2:0] run_cnt_t;

  localparam int unsigned HeldDepth = 3;
  localparam int unsigned RunMax    = 4;

  localparam byte_t    REPL_RESET = 8'h3F;
  localparam seq_len_t LEN_NONE   = 3'd0;
  localparam seq_len_t LEN_TWO    = 3'd2;
  localparam seq_len_t LEN_THREE  = 3'd3;
  localparam seq_len_t LEN_FOUR   = 3'd4;

endpackage

// ===== hw/rtl/utf8_stream_sanitizer.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_stall   in_byte
// out      source     out_valid / out_stall out_byte, last_of_run
// cfg      sink       cfg_write_en          cfg_write_data
//
// Each accepted request loads its results into a four byte output buffer.
// Requests that give zero or one byte flow at one per cycle while the output is not stalled.
// A request that gives more than one byte holds the input stalled while the buffer drains.
// Reset is synchronous; it empties the buffer, drops held bytes and restores '?'.
// Output stall freezes the buffer; input is stalled only while the buffer is still busy.

module utf8_stream_sanitizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  u8san_pkg::byte_t  in_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output u8san_pkg::byte_t  out_byte,
  output logic              last_of_run,
  input  logic              cfg_write_en,
  input  u8san_pkg::byte_t  cfg_write_data
);

  import u8san_pkg::*;

  byte_t     replacement_byte;
  byte_t     held_bytes [HeldDepth];
  held_cnt_t held_count;
  held_cnt_t held_count_next;
  seq_len_t  expected_length;
  seq_len_t  expected_length_next;
  byte_t     obuf [RunMax];
  run_cnt_t  ocnt;

  logic      in_accept;
  logic      out_pop;
  logic      fresh_emit;
  byte_t     fresh_byte;
  seq_len_t  fresh_len;
  logic      is_cont;
  logic      complete;
  logic      held_wr;
  held_cnt_t held_wr_idx;
  byte_t     res_bytes [RunMax];
  run_cnt_t  res_cnt;

  assign out_valid   = (ocnt != '0);
  assign out_byte    = obuf[0];
  assign last_of_run = (ocnt == run_cnt_t'(1));
  assign out_pop     = out_valid && !out_stall;
  assign in_stall    = !((ocnt == '0) || ((ocnt == run_cnt_t'(1)) && out_pop));
  assign in_accept   = in_valid && !in_stall;

  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign complete = ({1'b0, held_count} + 3'd1) >= expected_length;

  always_comb begin
    fresh_emit = 1'b1;
    fresh_byte = replacement_byte;
    fresh_len  = LEN_NONE;
    if (!in_byte[7]) begin
      fresh_byte = in_byte;
    end else if (!in_byte[6]) begin
      fresh_byte = replacement_byte;
    end else if (!in_byte[5]) begin
      fresh_emit = 1'b0;
      fresh_len  = LEN_TWO;
    end else if (!in_byte[4]) begin
      fresh_emit = 1'b0;
      fresh_len  = LEN_THREE;
    end else if (!in_byte[3]) begin
      fresh_emit = 1'b0;
      fresh_len  = LEN_FOUR;
    end
  end

  always_comb begin
    for (int i = 0; i < RunMax; i++) begin
      res_bytes[i] = in_byte;
    end
    res_cnt              = '0;
    held_count_next      = held_count;
    expected_length_next = expected_length;
    held_wr              = 1'b0;
    held_wr_idx          = '0;

    if (held_count == '0) begin
      res_bytes[0] = fresh_byte;
      res_cnt      = run_cnt_t'(fresh_emit);
      if (!fresh_emit) begin
        held_wr              = 1'b1;
        held_count_next      = held_cnt_t'(1);
        expected_length_next = fresh_len;
      end
    end else if (is_cont && !complete) begin
      held_wr         = 1'b1;
      held_wr_idx     = held_count;
      held_count_next = held_count + held_cnt_t'(1);
    end else begin
      for (int i = 0; i < HeldDepth; i++) begin
        if (held_cnt_t'(i) < held_count) begin
          res_bytes[i] = is_cont ? held_bytes[i] : replacement_byte;
        end
      end
      res_bytes[held_count] = is_cont ? in_byte : fresh_byte;
      res_cnt = {1'b0, held_count} + run_cnt_t'(is_cont || fresh_emit);
      held_count_next      = '0;
      expected_length_next = LEN_NONE;
      if (!is_cont && !fresh_emit) begin
        held_wr              = 1'b1;
        held_count_next      = held_cnt_t'(1);
        expected_length_next = fresh_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_byte <= REPL_RESET;
    end else if (cfg_write_en) begin
      replacement_byte <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= '0;
      expected_length <= LEN_NONE;
    end else if (in_accept) begin
      held_count      <= held_count_next;
      expected_length <= expected_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && held_wr) begin
      held_bytes[held_wr_idx] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else if (in_accept) begin
      ocnt <= res_cnt;
    end else if (out_pop) begin
      ocnt <= ocnt - run_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < RunMax; i++) begin
        obuf[i] <= res_bytes[i];
      end
    end else if (out_pop) begin
      for (int i = 0; i < RunMax - 1; i++) begin
        obuf[i] <= obuf[i + 1];
      end
    end
  end

endmodule

// ===== hw/rtl/u8san_checker.sv =====
`timescale 1ns / 1ps

module u8san_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input u8san_pkg::byte_t  in_byte,
  input logic              out_valid,
  input logic              out_stall,
  input u8san_pkg::byte_t  out_byte,
  input logic              last_of_run,
  input logic              cfg_write_en,
  input u8san_pkg::byte_t  cfg_write_data
);

  import u8san_pkg::*;

  // A stalled result stays in place with the same bytes.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled output changed");

  // Input is only held back while results are still waiting.
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with nothing pending");

  // A run that is not finished keeps the input stalled.
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> in_stall)
    else $error("input open in the middle of a run");

  // Taking a byte that is not the last of its run leaves more to send.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("run ended without a last byte");

  // An accepted request always comes with a defined byte.
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !$isunknown(in_byte))
    else $error("unknown input byte accepted");

endmodule

bind utf8_stream_sanitizer u8san_checker u_u8san_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_byte        (in_byte),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .last_of_run    (last_of_run),
  .cfg_write_en   (cfg_write_en),
  .cfg_write_data (cfg_write_data)
);

// ===== tb/sv/utf8_stream_sanitizer_tb.sv =====
`timescale 1ns / 1ps

module utf8_stream_sanitizer_tb;
  import u8san_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  last;
  } result_t;

  typedef struct packed {
    byte_t data;
    bit    typed;
    byte_t want;
  } dir_row_t;

  localparam int unsigned NumDirected = 25;
  localparam int unsigned PhaseItems  = 24;
  localparam int unsigned HoldAt      = 45;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned IdlePct     = 23;

  localparam dir_row_t DirRows [NumDirected] = '{
    '{8'h00, 1'b1, 8'h00},
    '{8'h7F, 1'b1, 8'h7F},
    '{8'hFF, 1'b1, REPL_RESET},
    '{8'hF8, 1'b1, REPL_RESET},
    '{8'h80, 1'b1, REPL_RESET},
    '{8'hC3, 1'b0, 8'h00},
    '{8'hA9, 1'b0, 8'h00},
    '{8'hE2, 1'b0, 8'h00},
    '{8'h82, 1'b0, 8'h00},
    '{8'hAC, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 8'h00},
    '{8'h9F, 1'b0, 8'h00},
    '{8'h98, 1'b0, 8'h00},
    '{8'h80, 1'b0, 8'h00},
    '{8'hC3, 1'b0, 8'h00},
    '{8'h41, 1'b0, 8'h00},
    '{8'hE2, 1'b0, 8'h00},
    '{8'h82, 1'b0, 8'h00},
    '{8'hF8, 1'b0, 8'h00},
    '{8'hF4, 1'b0, 8'h00},
    '{8'h8F, 1'b0, 8'h00},
    '{8'hC2, 1'b0, 8'h00},
    '{8'h80, 1'b0, 8'h00},
    '{8'hE0, 1'b0, 8'h00},
    '{8'h20, 1'b0, 8'h00}
  };

  logic  clk            = 1'b0;
  logic  rst            = 1'b1;
  logic  in_valid       = 1'b0;
  logic  in_stall;
  byte_t in_byte        = 8'h00;
  logic  out_valid;
  logic  out_stall      = 1'b0;
  byte_t out_byte;
  logic  last_of_run;
  logic  cfg_write_en   = 1'b0;
  byte_t cfg_write_data = 8'h00;

  byte_t     repl_byte = REPL_RESET;
  byte_t     held_seq [HeldDepth];
  held_cnt_t held_n    = '0;
  seq_len_t  seq_len   = LEN_NONE;
  result_t   run_q[$];
  result_t   pending_out[$];
  byte_t     burst_q[$];

  bit    cur_typed   = 1'b0;
  byte_t cur_want    = 8'h00;
  bit    calm        = 1'b0;
  int    items_sent  = 0;
  int    errors      = 0;

  utf8_stream_sanitizer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .last_of_run    (last_of_run),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  function automatic void take_fresh(byte_t b);
    if (!b[7]) begin
      run_q.push_back(result_t'{b, 1'b0});
    end else if (!b[6]) begin
      run_q.push_back(result_t'{repl_byte, 1'b0});
    end else begin
      if (!b[5]) begin
        seq_len = LEN_TWO;
      end else if (!b[4]) begin
        seq_len = LEN_THREE;
      end else if (!b[3]) begin
        seq_len = LEN_FOUR;
      end else begin
        run_q.push_back(result_t'{repl_byte, 1'b0});
        return;
      end
      held_seq[0] = b;
      held_n = 2'd1;
    end
  endfunction

  function automatic void sanitize_byte(byte_t b);
    run_q.delete();
    if (held_n == 0) begin
      take_fresh(b);
    end else if (b[7:6] == 2'b10) begin
      if (int'(held_n) + 1 >= int'(seq_len)) begin
        for (int i = 0; i < int'(held_n); i++) begin
          run_q.push_back(result_t'{held_seq[i], 1'b0});
        end
        run_q.push_back(result_t'{b, 1'b0});
        held_n = '0;
        seq_len = LEN_NONE;
      end else begin
        held_seq[held_n] = b;
        held_n = held_n + 2'd1;
      end
    end else begin
      for (int i = 0; i < int'(held_n); i++) begin
        run_q.push_back(result_t'{repl_byte, 1'b0});
      end
      held_n = '0;
      seq_len = LEN_NONE;
      take_fresh(b);
    end
    if (run_q.size() > 0) begin
      run_q[run_q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic byte_t lead_of(int len);
    byte_t r;
    r = byte_t'($urandom_range(255));
    case (len)
      2: begin
        r = {3'b110, r[4:0]};
      end
      3: begin
        r = {4'b1110, r[3:0]};
      end
      default: begin
        r = {5'b11110, r[2:0]};
      end
    endcase
    return r;
  endfunction

  task automatic build_burst();
    int k;
    int len;
    int conts;
    k = $urandom_range(99);
    burst_q.delete();
    if (k < 35) begin
      burst_q.push_back(byte_t'($urandom_range(127)));
    end else if (k < 87) begin
      len = $urandom_range(4, 2);
      conts = (k < 75) ? len - 1 : $urandom_range(len - 2, 0);
      burst_q.push_back(lead_of(len));
      for (int i = 0; i < conts; i++) begin
        burst_q.push_back({2'b10, 6'($urandom_range(63))});
      end
    end else begin
      burst_q.push_back(byte_t'($urandom_range(255)));
    end
  endtask

  task automatic offer_byte(byte_t b, bit typed, byte_t want);
    bit took;
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    cur_typed = typed;
    cur_want = want;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_repl(byte_t v);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    repl_byte = v;
  endtask

  always @(negedge clk) begin : out_check
    result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sanitize_byte(in_byte);
        if (cur_typed) begin
          pending_out.push_back(result_t'{cur_want, 1'b1});
        end else begin
          foreach (run_q[i]) begin
            pending_out.push_back(run_q[i]);
          end
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_out.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected output: out_byte %h last_of_run %b", out_byte, last_of_run);
          end
        end else begin
          want = pending_out.pop_front();
          if (out_byte !== want.data || last_of_run !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected out_byte %h last_of_run %b, got %h %b",
                       want.data, want.last, out_byte, last_of_run);
            end
          end
        end
      end
    end
  end

  initial begin : rx_side
    int  hold_left;
    bit  hold_done;
    bit  nxt;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= HoldAt) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else begin
        nxt = !calm && $urandom_range(99) < IdlePct;
      end
      @(posedge clk);
      out_stall <= nxt;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(negedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int    count;
    byte_t repl_values [4];
    repl_values[0] = 8'h00;
    repl_values[1] = 8'hFF;
    repl_values[2] = byte_t'($urandom_range(255));
    repl_values[3] = REPL_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int r = 0; r < NumDirected; r++) begin
      offer_byte(DirRows[r].data, DirRows[r].typed, DirRows[r].want);
    end
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_repl(repl_values[ph]);
      calm = (ph == 2);
      count = 0;
      while (count < PhaseItems) begin
        build_burst();
        foreach (burst_q[i]) begin
          offer_byte(burst_q[i], 1'b0, 8'h00);
        end
        count += burst_q.size();
      end
      drain();
    end
    calm = 1'b0;
    if (pending_out.size() != 0) begin
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
